FILE: rtl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Result types, DFA state codes and the constant byte-class and transition
// tables of the UTF-8 decoding automaton.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int CODE_W  = 21;
    localparam int COUNT_W = 3;
    localparam int STATE_W = 4;
    localparam int CLASS_W = 4;

    localparam logic [STATE_W-1:0] ST_ACCEPT  = 4'd0;
    localparam logic [STATE_W-1:0] ST_REJECT  = 4'd1;
    localparam logic [STATE_W-1:0] NUM_STATES = 4'd9;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

    typedef struct packed {
        logic [CODE_W-1:0]  code_point;
        logic [COUNT_W-1:0] byte_count;
        logic               is_terminator;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } step_out_t;

    // Next state, indexed by current state and byte class.
    localparam logic [STATE_W-1:0] TRANS_ROM [0:8][0:11] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
    };

    // Byte class of the automaton; the 256-entry table written as ranges.
    function automatic logic [CLASS_W-1:0] byte_class(input logic [7:0] b);
        logic [CLASS_W-1:0] c;
        begin
            if (b < 8'h80)
                c = 4'd0;
            else if (b < 8'h90)
                c = 4'd1;
            else if (b < 8'hA0)
                c = 4'd9;
            else if (b < 8'hC0)
                c = 4'd7;
            else if (b < 8'hC2)
                c = 4'd8;
            else if (b < 8'hE0)
                c = 4'd2;
            else if (b == 8'hE0)
                c = 4'd10;
            else if (b == 8'hED)
                c = 4'd4;
            else if (b < 8'hF0)
                c = 4'd3;
            else if (b == 8'hF0)
                c = 4'd11;
            else if (b < 8'hF4)
                c = 4'd6;
            else if (b == 8'hF4)
                c = 4'd5;
            else
                c = 4'd8;
            return c;
        end
    endfunction

endpackage

FILE: rtl/utf8d_core.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder core
// Holds the DFA state, the code point accumulator and the byte count, and
// works out the result of the byte at its input in a single pass.
// ----------------------------------------------------------------------------
module utf8d_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           data_byte,
    input  logic                 cfg_we,
    input  logic                 cfg_data,
    output utf8d_pkg::step_out_t res
);
    import utf8d_pkg::*;

    logic [STATE_W-1:0] state_reg,   state_next;
    logic [CODE_W-1:0]  partial_reg, partial_next;
    logic [COUNT_W-1:0] seen_reg,    seen_next;
    logic               ended_reg,   ended_next;
    logic               emit_reg;

    logic [CLASS_W-1:0] cls;
    logic [STATE_W-1:0] dfa_next;
    logic [7:0]         lead_bits;
    logic [COUNT_W-1:0] seen_inc;

    assign cls       = byte_class(data_byte);
    assign lead_bits = (8'hFF >> cls) & data_byte;
    assign seen_inc  = (seen_reg < COUNT_MAX) ? seen_reg + 3'd1 : seen_reg;

    always_comb
    begin
        dfa_next = ST_REJECT;
        if (state_reg < NUM_STATES)
            dfa_next = TRANS_ROM[state_reg][cls];
    end

    always_comb
    begin
        state_next   = state_reg;
        partial_next = partial_reg;
        seen_next    = seen_reg;
        ended_next   = ended_reg;
        res          = '0;
        if (!ended_reg) begin
            if (data_byte == 8'h00) begin
                // The zero byte ends the string in any DFA state.
                ended_next             = 1'b1;
                res.valid              = emit_reg;
                res.data.byte_count    = 3'd1;
                res.data.is_terminator = 1'b1;
            end else if (state_reg == ST_REJECT || state_reg >= NUM_STATES) begin
                state_next = ST_REJECT;
            end else begin
                if (state_reg == ST_ACCEPT)
                    partial_next = {{(CODE_W-8){1'b0}}, lead_bits};
                else
                    partial_next = {partial_reg[CODE_W-7:0], data_byte[5:0]};
                state_next = dfa_next;
                if (dfa_next != ST_REJECT) begin
                    if (dfa_next == ST_ACCEPT) begin
                        res.valid           = 1'b1;
                        res.data.code_point = partial_next;
                        res.data.byte_count = seen_inc;
                        seen_next           = '0;
                    end else begin
                        seen_next = seen_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= ST_ACCEPT;
            partial_reg <= '0;
            seen_reg    <= '0;
            ended_reg   <= 1'b0;
            emit_reg    <= 1'b0;
        end else begin
            if (cfg_we)
                emit_reg <= cfg_data;
            if (step) begin
                state_reg   <= state_next;
                partial_reg <= partial_next;
                seen_reg    <= seen_next;
                ended_reg   <= ended_next;
            end
        end
    end

endmodule

FILE: rtl/utf8_dfa_decoder.sv
// ----------------------------------------------------------------------------
// UTF-8 DFA decoder
// Decodes a UTF-8 byte stream into code points with their byte counts.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    data_byte
//   out      output     out_valid / out_ready  code_point, byte_count,
//                                              is_terminator
//   cfg      input      cfg_valid / cfg_ready  cfg_data (emit_terminator)
//
// One byte is accepted per cycle unless input stalls; its result, if any,
// enters the output register, or the skid register while the output stalls.
// The core decodes a byte with a class lookup, a transition lookup and a shift.
// A two-entry output queue (output register plus skid register) lets input
// continue while one result waits; input stalls only when both are full.
// Reset puts the DFA in the accept state, clears the end-of-string flag and
// the emit_terminator register, and empties the output queue.
// ----------------------------------------------------------------------------
module utf8_dfa_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [20:0] code_point,
    output logic [2:0]  byte_count,
    output logic        is_terminator,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);
    import utf8d_pkg::*;

    step_out_t res;
    logic      in_fire;
    logic      out_fire;

    logic      out_valid_reg,  out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    result_t   out_data_reg,   out_data_next;
    result_t   skid_data_reg,  skid_data_next;

    assign cfg_ready = 1'b1;
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;

    utf8d_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_fire),
        .data_byte (data_byte),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            // No new input while the skid register is full.
            if (out_ready) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (in_fire && res.valid) begin
            if (!out_valid_reg || out_ready) begin
                out_data_next  = res.data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = res.data;
                skid_valid_next = 1'b1;
            end
        end else if (out_fire) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid     = out_valid_reg;
    assign code_point    = out_data_reg.code_point;
    assign byte_count    = out_data_reg.byte_count;
    assign is_terminator = out_data_reg.is_terminator;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output is empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (byte_count != 3'd0 && byte_count <= 3'd4))
        else $error("byte count out of range");

    a_terminator_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && is_terminator) |-> (code_point == '0 && byte_count == 3'd1))
        else $error("terminator result carries a code point");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && res.valid) |=> out_valid_reg)
        else $error("accepted result did not reach the output register");

endmodule
